// File: rtl/g2r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// g2r_pkg
// Shared types and constants for the 2bpp glyph row repacker.
// ----------------------------------------------------------------------------
package g2r_pkg;

   // Result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Source item: one row-aligned byte plus glyph dimensions
   typedef struct packed {
      logic [7:0] src_byte;
      logic [7:0] glyph_width;
      logic [7:0] glyph_height;
   } req_item_type;

   // Result item: one packed byte
   typedef struct packed {
      logic [7:0] packed_byte;
      logic       glyph_done;
   } rsp_item_type;

   // Up to two results per source byte, oldest in first
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } g2r_push_type;

endpackage : g2r_pkg
`default_nettype wire

// File: rtl/glyph_2bpp_row_repacker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_2bpp_row_repacker
// Strips row padding from a 2bpp glyph bitmap and packs pixels back to back.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one source byte per transaction together with the glyph
//   width and height; the dimensions count only on the first byte of a
//   glyph. A first byte with zero width or height is dropped.
//   rsp_* carries one packed byte per transaction; glyph_done marks the
//   last packed byte of a glyph. A source byte yields zero, one or two
//   packed bytes.
//   A packed byte passes through the input register, then the pack step
//   into the result queue, and is offered from the head of the queue.
//   Throughput: one source byte per cycle while each byte yields at most one
//   result and the receiver does not stall; the single-transaction result
//   port sets the limit.
//   Reset clears the glyph state, the input register and the result queue.
//   When the receiver stalls, results collect in a four-entry queue; the
//   input register holds once fewer than two queue slots remain, and
//   req_stall rises while it holds.
// ----------------------------------------------------------------------------
module glyph_2bpp_row_repacker
   import g2r_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_data
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         room_two;
   logic         process;
   logic         req_take;
   g2r_push_type push;

   // Process the held transaction when the queue has room for two results
   assign process   = in_valid_ff && room_two;
   assign req_stall = in_valid_ff && !room_two;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !process);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
   end

   g2r_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .item_valid (process),
      .item       (in_item_ff),
      .push       (push)
   );

   g2r_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_two  (room_two),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule : glyph_2bpp_row_repacker
`default_nettype wire

// File: rtl/g2r_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// g2r_pack
// Per-byte repacking step: trims row padding, merges the kept pixels into
// the pending pixels and produces up to two packed bytes.
// ----------------------------------------------------------------------------
module g2r_pack
   import g2r_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  wire req_item_type item,
   output g2r_push_type      push
);

   logic [5:0] pixel_accum_ff,  pixel_accum_in;
   logic [1:0] accum_pixels_ff, accum_pixels_in;
   logic [5:0] byte_in_row_ff,  byte_in_row_in;
   logic [7:0] row_count_ff,    row_count_in;
   logic       in_glyph_ff,     in_glyph_in;
   logic [7:0] held_width_ff,   held_width_in;
   logic [7:0] held_height_ff,  held_height_in;

   logic        first;
   logic [7:0]  width_cur;
   logic [7:0]  height_cur;
   logic        zero_dim;
   logic [5:0]  accum_cur;
   logic [1:0]  np_cur;
   logic [5:0]  bir_cur;
   logic [7:0]  row_cur;
   logic [8:0]  stride_wide;
   logic [6:0]  stride;
   logic        row_end;
   logic [2:0]  take;
   logic [2:0]  total;
   logic [13:0] combo;
   logic        glyph_end;
   logic        full;
   logic [1:0]  spare;
   logic [13:0] full_shift;
   logic [5:0]  keep_mask;
   logic [5:0]  acc_next;
   logic [1:0]  np_next;
   logic [7:0]  partial_byte;
   logic        has_partial;
   rsp_item_type full_item;
   rsp_item_type part_item;

   // Merge the source pixels with the pending ones
   always_comb begin
      first      = !in_glyph_ff;
      width_cur  = first ? item.glyph_width  : held_width_ff;
      height_cur = first ? item.glyph_height : held_height_ff;
      zero_dim   = (width_cur == 8'd0) || (height_cur == 8'd0);
      accum_cur  = first ? 6'd0 : pixel_accum_ff;
      np_cur     = first ? 2'd0 : accum_pixels_ff;
      bir_cur    = first ? 6'd0 : byte_in_row_ff;
      row_cur    = first ? 8'd0 : row_count_ff;

      stride_wide = ({1'b0, width_cur} + 9'd3) >> 2;
      stride      = stride_wide[6:0];
      row_end     = ({1'b0, bir_cur} + 7'd1) >= stride;
      take        = row_end ? ({1'b0, width_cur[1:0] - 2'd1} + 3'd1) : 3'd4;
      total       = {1'b0, np_cur} + take;
      combo       = ({8'd0, accum_cur} << {take, 1'b0})
                  | ({6'd0, item.src_byte} >> (4'd8 - {take, 1'b0}));
      glyph_end   = row_end && (({1'b0, row_cur} + 9'd1) >= {1'b0, height_cur});

      // Emit a full byte when four or more pixels are on hand
      full       = total[2];
      spare      = total[1:0];
      full_shift = combo >> {spare, 1'b0};
      keep_mask  = ~(6'h3F << {spare, 1'b0});
      if (full) begin
         acc_next = combo[5:0] & keep_mask;
         np_next  = spare;
      end else begin
         acc_next = combo[5:0];
         np_next  = total[1:0];
      end

      // Flush leftover pixels at glyph end, zero padded in the low bits
      partial_byte = ({2'd0, acc_next} << (4'd8 - {np_next, 1'b0}));
      has_partial  = glyph_end && (np_next != 2'd0);

      full_item.packed_byte = full_shift[7:0];
      full_item.glyph_done  = glyph_end && (spare == 2'd0);
      part_item.packed_byte = partial_byte;
      part_item.glyph_done  = 1'b1;
   end

   // Order results: full byte first, partial byte after
   always_comb begin
      push.count  = 2'd0;
      push.first  = full_item;
      push.second = part_item;
      if (item_valid && !(first && zero_dim)) begin
         if (full && has_partial) begin
            push.count = 2'd2;
         end else if (full) begin
            push.count = 2'd1;
         end else if (has_partial) begin
            push.count = 2'd1;
            push.first = part_item;
         end
      end
   end

   // Next state
   always_comb begin
      pixel_accum_in  = pixel_accum_ff;
      accum_pixels_in = accum_pixels_ff;
      byte_in_row_in  = byte_in_row_ff;
      row_count_in    = row_count_ff;
      in_glyph_in     = in_glyph_ff;
      held_width_in   = held_width_ff;
      held_height_in  = held_height_ff;
      if (item_valid) begin
         if (first) begin
            held_width_in  = item.glyph_width;
            held_height_in = item.glyph_height;
         end
         if (!(first && zero_dim)) begin
            if (glyph_end) begin
               pixel_accum_in  = 6'd0;
               accum_pixels_in = 2'd0;
               byte_in_row_in  = 6'd0;
               row_count_in    = 8'd0;
               in_glyph_in     = 1'b0;
            end else begin
               pixel_accum_in  = acc_next;
               accum_pixels_in = np_next;
               in_glyph_in     = 1'b1;
               if (row_end) begin
                  byte_in_row_in = 6'd0;
                  row_count_in   = row_cur + 8'd1;
               end else begin
                  byte_in_row_in = bir_cur + 6'd1;
                  row_count_in   = row_cur;
               end
            end
         end
      end
   end

   // Hold state between bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_accum_ff  <= 6'd0;
         accum_pixels_ff <= 2'd0;
         byte_in_row_ff  <= 6'd0;
         row_count_ff    <= 8'd0;
         in_glyph_ff     <= 1'b0;
         held_width_ff   <= 8'd0;
         held_height_ff  <= 8'd0;
      end else begin
         pixel_accum_ff  <= pixel_accum_in;
         accum_pixels_ff <= accum_pixels_in;
         byte_in_row_ff  <= byte_in_row_in;
         row_count_ff    <= row_count_in;
         in_glyph_ff     <= in_glyph_in;
         held_width_ff   <= held_width_in;
         held_height_ff  <= held_height_in;
      end
   end

endmodule : g2r_pack
`default_nettype wire

// File: rtl/g2r_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// g2r_queue
// Small result queue: takes up to two results a cycle, hands out one
// transaction a cycle on the result channel while the receiver does not stall.
// ----------------------------------------------------------------------------
module g2r_queue
   import g2r_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire g2r_push_type push,
   output logic              room_two,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_data
);

   rsp_item_type entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff,  count_in;
   logic                   pop;
   logic [QUEUE_CNT_W-1:0] after_pop;
   logic [QUEUE_PTR_W-1:0] wr_next_slot;

   // Drive the result channel from the head entry
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entries_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // Space check counts the entry leaving this cycle
   assign after_pop = count_ff - QUEUE_CNT_W'(pop);
   assign room_two  = after_pop <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);

   assign wr_next_slot = wr_ptr_ff + QUEUE_PTR_W'(1);
   assign wr_ptr_in    = wr_ptr_ff + QUEUE_PTR_W'(push.count);
   assign rd_ptr_in    = rd_ptr_ff + QUEUE_PTR_W'(pop);
   assign count_in     = after_pop + QUEUE_CNT_W'(push.count);

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store results
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next_slot] <= push.second;
      end
   end

endmodule : g2r_queue
`default_nettype wire
